// File: rtl/core/cdf_max_distance_score_top_macros.svh
// Assertion helpers for the distance score block.
`ifndef CDF_MAX_DISTANCE_SCORE_TOP_MACROS_SVH
`define CDF_MAX_DISTANCE_SCORE_TOP_MACROS_SVH

`ifndef SYNTH
// Property that holds at every clock edge outside reset.
`define CDFMD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("cdfmd assertion failed");
// Condition in one cycle forces a consequence in the next.
`define CDFMD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("cdfmd assertion failed");
`else
`define CDFMD_ASSERT(lbl, clk, rstn, prop)
`define CDFMD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/cdfmd_pkg.sv
// ----------------------------------------------------------------------------
// cdfmd_pkg
// Shared widths, constants and case codes of the distance score block.
// ----------------------------------------------------------------------------
package cdfmd_pkg;

  localparam int unsigned ChargeW        = 24;
  localparam int unsigned ScoreW         = 17;
  localparam int unsigned CodeW          = 2;
  localparam int unsigned FracSteps      = 16;
  localparam int unsigned NumChannelsDef = 32;

  localparam logic [ScoreW-1:0] ScoreOne = ScoreW'(1 << FracSteps);

  typedef enum logic [CodeW-1:0] {
    CaseNormal   = 2'd0,
    CaseOneZero  = 2'd1,
    CaseBothZero = 2'd2
  } case_e;

endpackage

// File: rtl/core/cdf_max_distance_score_top.sv
// ----------------------------------------------------------------------------
// cdf_max_distance_score_top
// Two-sample Kolmogorov-Smirnov distance between measured and predicted
// charge patterns of one flash.
// ----------------------------------------------------------------------------
// Input stream: one request per channel, measured and predicted charge in
// tdata, tlast on the final channel. A flash also closes when it reaches
// NUM_CHANNELS channels. Channels are taken one per cycle and their running
// prefix sums go to a single-port-write store.
// After the closing channel the block stops taking requests. A check state
// tests for zero totals; a flash with a zero total goes from there straight
// to the output state. Otherwise the block walks the stored channels
// one read per cycle through a three-stage pipe (store read, cross-multiply,
// max), then a restoring divider yields the Q1.16 score.
// Output stream: one request per flash, score and case code in tdata, held
// in an output register. Input is taken again as soon as the result is
// registered; a stalled receiver only holds a later flash at its end.
// Reset clears totals, channel count and the output valid; the store needs
// no clearing, since every entry read was written in the same flash.
// ----------------------------------------------------------------------------
module cdf_max_distance_score_top
  import cdfmd_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // data_pe[23:0], hypo_pe[47:24]
  input  logic        s_axis_tlast,  // last_channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // score[16:0], case_code[18:17], zeros
);

  `include "cdf_max_distance_score_top_macros.svh"

  localparam int unsigned IdxW  = $clog2(NUM_CHANNELS);
  localparam int unsigned CntW  = $clog2(NUM_CHANNELS + 1);
  localparam int unsigned PfxW  = ChargeW + IdxW;
  localparam int unsigned ProdW = 2 * PfxW;

  typedef enum logic [2:0] {
    StLoad,
    StCheck,
    StWalk,
    StDiv,
    StOut
  } state_e;

  state_e            state_q;
  logic [PfxW-1:0]   tot_d_q;
  logic [PfxW-1:0]   tot_h_q;
  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   issue_q;
  logic              v1_q, l1_q, v2_q, l2_q, l3_q;
  logic [ScoreW-1:0] res_score_q;
  case_e             res_code_q;
  logic              out_valid_q;
  logic [ScoreW-1:0] out_score_q;
  case_e             out_code_q;

  logic [ProdW-1:0]  dh_q;
  logic [ProdW-1:0]  a_q;
  logic [ProdW-1:0]  b_q;
  logic [ProdW-1:0]  best_q;

  logic [ChargeW-1:0] data_pe;
  logic [ChargeW-1:0] hypo_pe;
  logic               in_acc;
  logic [PfxW-1:0]    sum_d;
  logic [PfxW-1:0]    sum_h;
  logic               closing;
  logic               issue;
  logic [2*PfxW-1:0]  rdata;
  logic [PfxW-1:0]    rd_d;
  logic [PfxW-1:0]    rd_h;
  logic [ProdW-1:0]   gap;
  logic               div_start;
  logic               div_done;
  logic [ScoreW-1:0]  div_quot;
  logic               out_free;

  assign data_pe = s_axis_tdata[ChargeW-1:0];
  assign hypo_pe = s_axis_tdata[2*ChargeW-1:ChargeW];

  assign s_axis_tready = (state_q == StLoad);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign sum_d         = tot_d_q + PfxW'(data_pe);
  assign sum_h         = tot_h_q + PfxW'(hypo_pe);
  // A full store closes the flash as if tlast were set.
  assign closing       = s_axis_tlast || (cnt_q == CntW'(NUM_CHANNELS - 1));

  assign issue     = (state_q == StWalk) && (issue_q != cnt_q);
  assign rd_d      = rdata[PfxW-1:0];
  assign rd_h      = rdata[2*PfxW-1:PfxW];
  assign gap       = (a_q >= b_q) ? (a_q - b_q) : (b_q - a_q);
  assign div_start = (state_q == StWalk) && l3_q;
  assign out_free  = !out_valid_q || m_axis_tready;

  cdfmd_mem #(
    .Depth (NUM_CHANNELS),
    .DataW (2 * PfxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i ({sum_h, sum_d}),
    .re_i    (issue),
    .raddr_i (issue_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  cdfmd_div #(
    .Width (ProdW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (best_q),
    .den_i   (dh_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      tot_d_q     <= '0;
      tot_h_q     <= '0;
      cnt_q       <= '0;
      issue_q     <= '0;
      v1_q        <= 1'b0;
      l1_q        <= 1'b0;
      v2_q        <= 1'b0;
      l2_q        <= 1'b0;
      l3_q        <= 1'b0;
      res_score_q <= '0;
      res_code_q  <= CaseNormal;
      out_valid_q <= 1'b0;
      out_score_q <= '0;
      out_code_q  <= CaseNormal;
    end else begin
      if ((state_q == StOut) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      v1_q <= issue;
      l1_q <= issue && (issue_q == cnt_q - CntW'(1));
      v2_q <= v1_q;
      l2_q <= l1_q;
      l3_q <= l2_q;
      case (state_q)
        StLoad: begin
          if (in_acc) begin
            tot_d_q <= sum_d;
            tot_h_q <= sum_h;
            cnt_q   <= cnt_q + CntW'(1);
            if (closing) begin
              state_q <= StCheck;
            end
          end
        end
        StCheck: begin
          issue_q <= '0;
          if (tot_d_q == '0 && tot_h_q == '0) begin
            res_score_q <= '0;
            res_code_q  <= CaseBothZero;
            state_q     <= StOut;
          end else if (tot_d_q == '0 || tot_h_q == '0) begin
            res_score_q <= ScoreOne;
            res_code_q  <= CaseOneZero;
            state_q     <= StOut;
          end else begin
            state_q <= StWalk;
          end
        end
        StWalk: begin
          if (issue) begin
            issue_q <= issue_q + CntW'(1);
          end
          if (l3_q) begin
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (div_done) begin
            res_score_q <= (div_quot > ScoreOne) ? ScoreOne : div_quot;
            res_code_q  <= CaseNormal;
            state_q     <= StOut;
          end
        end
        StOut: begin
          if (out_free) begin
            out_score_q <= res_score_q;
            out_code_q  <= res_code_q;
            tot_d_q     <= '0;
            tot_h_q     <= '0;
            cnt_q       <= '0;
            state_q     <= StLoad;
          end
        end
        default: begin
          state_q <= StLoad;
        end
      endcase
    end
  end

  // Cross-multiply pipe and running maximum.
  always_ff @(posedge clk_i) begin
    if (state_q == StCheck) begin
      dh_q   <= tot_d_q * tot_h_q;
      best_q <= '0;
    end else if (v2_q && (gap > best_q)) begin
      best_q <= gap;
    end
    if (v1_q) begin
      a_q <= rd_d * tot_h_q;
      b_q <= rd_h * tot_d_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_code_q, out_score_q};

  `CDFMD_ASSERT(a_score_range, clk_i, rst_ni,
                !out_valid_q || (out_score_q <= ScoreOne))
  `CDFMD_ASSERT(a_both_zero_score, clk_i, rst_ni,
                !(out_valid_q && (out_code_q == CaseBothZero)) || (out_score_q == '0))
  `CDFMD_ASSERT(a_div_in_div_state, clk_i, rst_ni,
                !div_done || (state_q == StDiv))
  `CDFMD_ASSERT_NEXT(a_close_to_check, clk_i, rst_ni,
                     in_acc && s_axis_tlast, state_q == StCheck)

endmodule

// File: rtl/core/cdfmd_mem.sv
// ----------------------------------------------------------------------------
// cdfmd_mem
// Prefix-sum store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cdfmd_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned DataW = 58
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/cdfmd_div.sv
// ----------------------------------------------------------------------------
// cdfmd_div
// Restoring fraction divider: floor(num * 2^16 / den) for num <= den,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cdfmd_div
  import cdfmd_pkg::*;
#(
  parameter int unsigned Width = 58
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [Width-1:0]  num_i,
  input  logic [Width-1:0]  den_i,
  output logic              done_o,
  output logic [ScoreW-1:0] quot_o
);

  localparam int unsigned StepW = $clog2(FracSteps + 1);

  logic [Width-1:0]  rem_q;
  logic [Width-1:0]  den_q;
  logic [ScoreW-1:0] quot_q;
  logic [StepW-1:0]  step_q;
  logic              busy_q;
  logic              done_q;

  logic [Width:0]    shifted;
  logic              ge;
  logic [Width:0]    diff;

  // First step compares the plain remainder, later ones the doubled one.
  assign shifted = (step_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == StepW'(FracSteps)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[Width-1:0] : shifted[Width-1:0];
      quot_q <= {quot_q[ScoreW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: bench/cdf_max_distance_score_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdf_max_distance_score_top_test
// Self-checking bench for the distance score block. Channels are streamed in
// per flash. The scores are worked out alongside by cross-multiplying the
// prefix sums and doing one exact division. Each result on the output
// stream is compared against the oldest predicted score. Directed flashes
// cover zero totals, full distance, extreme charges and a full store.
// Random flashes follow under several idle and stall mixes.
// ----------------------------------------------------------------------------
module cdf_max_distance_score_top_test;
  import cdfmd_pkg::*;

  localparam int unsigned NumCh        = NumChannelsDef;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned SettleCycles = NumCh + 40;
  localparam int unsigned RandomItems  = 1750;
  localparam logic [ChargeW-1:0] ChargeMax = '1;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    case_e             code;
  } score_t;

  typedef enum int unsigned {
    ChargeZero,
    ChargeSmall,
    ChargeHigh,
    ChargeSparse,
    ChargeFull
  } charge_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;   // data_pe[23:0], hypo_pe[47:24]
  logic        s_axis_tlast  = 1'b0; // last_channel
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // score[16:0], case_code[18:17], zeros

  // Running state of the score predictor
  logic [63:0] meas_prefix [NumCh];
  logic [63:0] pred_prefix [NumCh];
  logic [63:0] meas_sum = '0;
  logic [63:0] pred_sum = '0;
  int unsigned chan_cnt = 0;
  score_t      expected_scores [$];

  int unsigned error_count    = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  cdf_max_distance_score_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic score_t predict_score();
    score_t      res;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] diff;
    logic [63:0] best;
    logic [79:0] quot;
    best = '0;
    if (meas_sum == 0 && pred_sum == 0) begin
      res.score = '0;
      res.code  = CaseBothZero;
    end else if (meas_sum == 0 || pred_sum == 0) begin
      res.score = ScoreOne;
      res.code  = CaseOneZero;
    end else begin
      // compare d_i/D with h_i/H over the common denominator D*H
      for (int i = 0; i < chan_cnt; i++) begin
        a    = meas_prefix[i] * pred_sum;
        b    = pred_prefix[i] * meas_sum;
        diff = (a >= b) ? a - b : b - a;
        if (diff > best) best = diff;
      end
      quot = {best, 16'b0} / {16'b0, meas_sum * pred_sum};
      if (quot > ScoreOne) quot = ScoreOne;
      res.score = quot[ScoreW-1:0];
      res.code  = CaseNormal;
    end
    return res;
  endfunction

  task automatic take_channel(input logic [ChargeW-1:0] d, input logic [ChargeW-1:0] h,
                              input logic last);
    int unsigned slot;
    slot = (chan_cnt >= NumCh) ? NumCh - 1 : chan_cnt;
    meas_sum += d;
    pred_sum += h;
    meas_prefix[slot] = meas_sum;
    pred_prefix[slot] = pred_sum;
    chan_cnt = slot + 1;
    // close the flash on tlast or when the store is full
    if (last || chan_cnt >= NumCh) begin
      expected_scores = {expected_scores, predict_score()};
      meas_sum = '0;
      pred_sum = '0;
      chan_cnt = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk_i) begin : watch_input
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      take_channel(s_axis_tdata[23:0], s_axis_tdata[47:24], s_axis_tlast);
    end
  end

  always @(posedge clk_i) begin : check_result
    score_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_scores.size() == 0) begin
        report_mismatch("result with no flash pending", 32'(m_axis_tdata), 0);
      end else begin
        want = expected_scores.pop_front();
        if (m_axis_tdata[ScoreW-1:0] != want.score)
          report_mismatch("score", 32'(m_axis_tdata[ScoreW-1:0]), 32'(want.score));
        if (m_axis_tdata[ScoreW+CodeW-1:ScoreW] != want.code)
          report_mismatch("case code", 32'(m_axis_tdata[ScoreW+CodeW-1:ScoreW]),
                          32'(want.code));
        if (m_axis_tdata[23:ScoreW+CodeW] != '0)
          report_mismatch("padding", 32'(m_axis_tdata[23:ScoreW+CodeW]), 0);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_channel(input logic [ChargeW-1:0] d, input logic [ChargeW-1:0] h,
                              input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {h, d};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold the sender until every pending score has arrived, then let the block settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    // let the predictor take the last accepted channel first
    @(posedge clk_i);
    while (expected_scores.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic charge_mode_e pick_mode();
    int unsigned pick;
    pick = $urandom_range(7);
    return (pick >= ChargeFull) ? ChargeFull : charge_mode_e'(pick);
  endfunction

  function automatic logic [ChargeW-1:0] rand_charge(input charge_mode_e mode);
    case (mode)
      ChargeZero:   return '0;
      ChargeSmall:  return ChargeW'($urandom_range(255));
      ChargeHigh:   return ChargeMax - ChargeW'($urandom_range(255));
      ChargeSparse: return ($urandom_range(3) == 0) ? ChargeW'($urandom) : '0;
      default:      return ChargeW'($urandom);
    endcase
  endfunction

  task automatic test_zero_totals();
    send_channel('0, '0, 1'b1);
    send_channel(ChargeMax, '0, 1'b1);
    send_channel('0, ChargeMax, 1'b1);
    send_channel('0, '0, 1'b0);
    send_channel('0, '0, 1'b1);
    drain_results();
  endtask

  task automatic test_full_distance();
    // all measured charge before all predicted charge
    send_channel(ChargeMax, '0, 1'b0);
    send_channel('0, ChargeMax, 1'b1);
    send_channel(24'd1, '0, 1'b0);
    send_channel('0, 24'd1, 1'b1);
    drain_results();
  endtask

  task automatic test_extremes();
    send_channel(ChargeMax, ChargeMax, 1'b1);
    send_channel(24'd1, 24'd1, 1'b1);
    send_channel(ChargeMax, 24'd1, 1'b0);
    send_channel(24'd1, ChargeMax, 1'b1);
    send_channel(24'hAAAAAA, 24'h555555, 1'b0);
    send_channel(24'h555555, 24'hAAAAAA, 1'b1);
    drain_results();
  endtask

  task automatic test_store_full();
    // no tlast: the store closes the flash on its own
    for (int k = 0; k < NumCh; k++)
      send_channel(ChargeMax, ChargeW'($urandom), 1'b0);
    send_channel(24'd5, 24'd7, 1'b1);
    for (int k = 0; k < NumCh; k++)
      send_channel(ChargeW'($urandom), ChargeMax, k == NumCh - 1);
    drain_results();
  endtask

  task automatic test_random_flashes(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned n_items);
    int unsigned  sent;
    int unsigned  len;
    charge_mode_e dmode;
    charge_mode_e hmode;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0, 1:    len = $urandom_range(NumCh - 1, 9);
        2:       len = $urandom_range(NumCh + 8, NumCh);
        default: len = $urandom_range(8, 1);
      endcase
      dmode = pick_mode();
      hmode = pick_mode();
      for (int k = 0; k < len; k++)
        send_channel(rand_charge(dmode), rand_charge(hmode), k == len - 1);
      sent += len;
    end
    drain_results();
  endtask

  initial begin : run_tests
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_totals();
    test_full_distance();
    test_extremes();
    test_store_full();
    test_random_flashes(0, 0, RandomItems / 4);
    test_random_flashes(68, 0, RandomItems / 4);
    test_random_flashes(0, 68, RandomItems / 4);
    test_random_flashes(10, 10, RandomItems / 4);
    if (expected_scores.size() != 0)
      report_mismatch("scores never delivered", 32'(expected_scores.size()), 0);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
